/* sv/salru_pkg.sv */
// Shared types, constants and the divider step for the set-associative LRU hit counter.
package salru_pkg;

    localparam int ADDR_W      = 32;
    localparam int LB_W        = 13;
    localparam int SC_W        = 11;
    localparam int WC_W        = 4;
    localparam int TOTAL_W     = 48;
    localparam int STAMP_W     = 64;
    localparam int SET_FIELD_W = 16;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;
    localparam int ENTRY_W     = 1 + ADDR_W + STAMP_W;
    localparam int DIV_CYCLES  = ADDR_W / 2;
    localparam int CNT_W       = $clog2(DIV_CYCLES);

    localparam logic [1:0] REG_LINE_BYTES = 2'd0;
    localparam logic [1:0] REG_SET_COUNT  = 2'd1;
    localparam logic [1:0] REG_WAY_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_MOD,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_COMMIT
    } t_back_state;

    typedef struct packed {
        logic [ADDR_W-1:0]      line;
        logic [SET_FIELD_W-1:0] set;
    } t_job;

    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  tag;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic               hit;
        logic [2:0]         way_used;
        logic [TOTAL_W-1:0] total_hits;
        logic [TOTAL_W-1:0] total_misses;
    } t_result;

    typedef struct packed {
        logic [LB_W-1:0]   rem;
        logic [ADDR_W-1:0] quo;
    } t_div;

    // One restoring division step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(input logic [LB_W-1:0] rem, input logic [ADDR_W-1:0] quo,
                                      input logic [LB_W-1:0] dv);
        logic [LB_W:0] t;
        logic          q;
        t_div          r;
        t = {rem, quo[ADDR_W-1]};
        q = (t >= {1'b0, dv});
        if (q) begin
            t = t - {1'b0, dv};
        end
        r.rem = t[LB_W-1:0];
        r.quo = {quo[ADDR_W-2:0], q};
        return r;
    endfunction

endpackage

/* sv/set_assoc_lru_cache_hit_counter.sv */
// Top level of the set-associative LRU cache hit counter: config registers and the two halves.
//
//   channel   direction  handshake            payload
//   -------   ---------  -------------------  ------------------------------------------
//   address   in         push / full          i_address[31:0]
//   result    out        pop / empty          o_hit, o_way_used, o_total_hits/misses
//   config    in         psel/penable/pready  paddr[3:0], pwdata[31:0], prdata[31:0]
//
// The front takes an address, divides it by the line size for the line number, divides
// that by the set count for the set (two quotient bits per cycle in one shared divider)
// and hands the job off. The back checks one way per cycle of the set, up to way_count.
// After reset the back clears the tag store one set per cycle, all MAX_SETS sets, with
// full held high; config writes are taken meanwhile. A beat waiting at the result port
// holds the back in commit; the front runs on until the two-entry handoff queue fills.
module set_assoc_lru_cache_hit_counter
    import salru_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int MAX_SETS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [ADDR_W-1:0]  i_address,
    output logic               empty,
    input  logic               pop,
    output logic               o_hit,
    output logic [2:0]         o_way_used,
    output logic [TOTAL_W-1:0] o_total_hits,
    output logic [TOTAL_W-1:0] o_total_misses,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_WAYS + 1);

    logic [LB_W-1:0] r_line_bytes;
    logic [SC_W-1:0] r_set_count;
    logic [WC_W-1:0] r_way_count;
    logic [1:0]      w_reg_idx;
    logic            w_cfg_wr;

    logic [LB_W-1:0] w_lb_eff;
    logic [SC_W-1:0] w_sc_eff;
    logic [CW-1:0]   w_wc_eff;

    logic            w_clearing;
    logic            w_job_push;
    t_job            w_job_in;
    logic            w_job_full;
    t_job            w_job_out;
    logic            w_job_empty;
    logic            w_job_pop;
    t_result         w_result;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= LB_W'(64);
            r_set_count  <= SC_W'(64);
            r_way_count  <= WC_W'(8);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_LINE_BYTES: r_line_bytes <= pwdata[LB_W-1:0];
                REG_SET_COUNT:  r_set_count  <= pwdata[SC_W-1:0];
                REG_WAY_COUNT:  r_way_count  <= pwdata[WC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_LINE_BYTES: prdata = PDATA_W'(r_line_bytes);
            REG_SET_COUNT:  prdata = PDATA_W'(r_set_count);
            REG_WAY_COUNT:  prdata = PDATA_W'(r_way_count);
            default:        prdata = '0;
        endcase
    end

    // Clamp zero and out-of-range geometry.
    always_comb begin
        w_lb_eff = (r_line_bytes == '0) ? LB_W'(1) : r_line_bytes;
        if (r_set_count == '0) begin
            w_sc_eff = SC_W'(1);
        end else if (32'(r_set_count) > 32'(MAX_SETS)) begin
            w_sc_eff = SC_W'(MAX_SETS);
        end else begin
            w_sc_eff = r_set_count;
        end
        if (r_way_count == '0) begin
            w_wc_eff = CW'(1);
        end else if (32'(r_way_count) > 32'(MAX_WAYS)) begin
            w_wc_eff = CW'(MAX_WAYS);
        end else begin
            w_wc_eff = CW'(r_way_count);
        end
    end

    salru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_address   (i_address),
        .i_hold      (w_clearing),
        .o_full      (full),
        .i_line_bytes(w_lb_eff),
        .i_set_count (w_sc_eff),
        .o_job_push  (w_job_push),
        .o_job       (w_job_in),
        .i_job_full  (w_job_full)
    );

    salru_fifo #(
        .WIDTH($bits(t_job)),
        .DEPTH(2)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_push),
        .i_data (w_job_in),
        .o_full (w_job_full),
        .i_pop  (w_job_pop),
        .o_data (w_job_out),
        .o_empty(w_job_empty)
    );

    salru_back #(
        .MAX_WAYS(MAX_WAYS),
        .MAX_SETS(MAX_SETS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_way_count(w_wc_eff),
        .i_job      (w_job_out),
        .i_job_empty(w_job_empty),
        .o_job_pop  (w_job_pop),
        .o_clearing (w_clearing),
        .o_result   (w_result),
        .o_empty    (empty),
        .i_pop      (pop)
    );

    assign o_hit          = w_result.hit;
    assign o_way_used     = w_result.way_used;
    assign o_total_hits   = w_result.total_hits;
    assign o_total_misses = w_result.total_misses;

endmodule

/* sv/salru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/salru_fifo.sv */
// Short flop queue that decouples the address front end from the tag back end.
module salru_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

/* sv/salru_front.sv */
// Front end: takes an address, derives line number and set with a shared radix-4 divider.
module salru_front
    import salru_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [ADDR_W-1:0] i_address,
    input  logic              i_hold,
    output logic              o_full,
    input  logic [LB_W-1:0]   i_line_bytes,
    input  logic [SC_W-1:0]   i_set_count,
    output logic              o_job_push,
    output t_job              o_job,
    input  logic              i_job_full
);

    t_front_state      r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_quo, n_quo;
    logic [LB_W-1:0]   r_rem, n_rem;
    logic [LB_W-1:0]   r_div, n_div;
    logic [ADDR_W-1:0] r_line, n_line;
    t_div              w_d1, w_d2;

    // Two dependent quotient bits per cycle.
    assign w_d1 = div_step(r_rem, r_quo, r_div);
    assign w_d2 = div_step(w_d1.rem, w_d1.quo, r_div);

    assign o_full    = (r_state != F_IDLE) || i_hold;
    assign o_job.line = r_line;
    assign o_job.set  = SET_FIELD_W'(r_rem);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_quo      = r_quo;
        n_rem      = r_rem;
        n_div      = r_div;
        n_line     = r_line;
        o_job_push = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_push && !i_hold) begin
                    n_quo   = i_address;
                    n_rem   = '0;
                    n_div   = i_line_bytes;
                    n_cnt   = '0;
                    n_state = F_DIV;
                end
            end
            F_DIV: begin
                n_quo = w_d2.quo;
                n_rem = w_d2.rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    // quotient is the line number; divide it again by the set count
                    n_line  = w_d2.quo;
                    n_rem   = '0;
                    n_div   = LB_W'(i_set_count);
                    n_cnt   = '0;
                    n_state = F_MOD;
                end
            end
            F_MOD: begin
                n_quo = w_d2.quo;
                n_rem = w_d2.rem;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_job_full) begin
                    o_job_push = 1'b1;
                    n_state    = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_line <= n_line;
    end

endmodule

/* sv/salru_back.sv */
// Back end: reads one set, scans its ways for hit, empty or LRU, writes back, counts.
module salru_back
    import salru_pkg::*;
#(
    parameter int MAX_WAYS = 8,
    parameter int MAX_SETS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_WAYS+1)-1:0] i_way_count,
    input  t_job                          i_job,
    input  logic                          i_job_empty,
    output logic                          o_job_pop,
    output logic                          o_clearing,
    output t_result                       o_result,
    output logic                          o_empty,
    input  logic                          i_pop
);

    localparam int SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int CW = $clog2(MAX_WAYS + 1);

    t_back_state        r_state, n_state;
    logic [SW-1:0]      r_clr_addr;
    logic [STAMP_W-1:0] r_acc;
    logic [TOTAL_W-1:0] r_hits, n_hits;
    logic [TOTAL_W-1:0] r_misses, n_misses;
    logic               r_out_valid;
    t_result            r_out;

    logic [ADDR_W-1:0]  r_line, n_line;
    logic [SW-1:0]      r_set, n_set;
    logic [CW-1:0]      r_way, n_way;
    logic               r_hit, n_hit;
    logic               r_have_empty, n_have_empty;
    logic [WW-1:0]      r_empty_way, n_empty_way;
    logic               r_have_lru, n_have_lru;
    logic [WW-1:0]      r_lru_way, n_lru_way;
    logic [STAMP_W-1:0] r_lru_stamp, n_lru_stamp;

    logic [ENTRY_W-1:0] w_rdata [MAX_WAYS];
    logic [MAX_WAYS-1:0] w_we;
    logic [SW-1:0]      w_waddr;
    t_entry             w_wentry;
    t_entry             w_entry;
    logic [WW-1:0]      w_chosen;
    logic [31:0]        w_chosen32;
    logic [CW-1:0]      w_way_inc;
    logic               w_commit;
    logic               w_clear;

    assign w_clear    = (r_state == B_CLEAR);
    assign w_commit   = (r_state == B_COMMIT) && (!r_out_valid || i_pop);
    assign o_job_pop  = (r_state == B_IDLE) && !i_job_empty;
    assign o_clearing = w_clear;
    assign w_entry    = t_entry'(w_rdata[r_way[WW-1:0]]);
    assign w_way_inc  = r_way + CW'(1);
    assign w_chosen   = r_hit ? r_way[WW-1:0] : (r_have_empty ? r_empty_way : r_lru_way);
    assign w_chosen32 = 32'(w_chosen);

    assign w_waddr        = w_clear ? r_clr_addr : r_set;
    assign w_wentry.valid = !w_clear;
    assign w_wentry.tag   = w_clear ? '0 : r_line;
    assign w_wentry.stamp = w_clear ? '0 : r_acc;

    always_comb begin
        for (int i = 0; i < MAX_WAYS; i++) begin
            w_we[i] = w_clear || (w_commit && (w_chosen == WW'(i)));
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WAYS; g++) begin : g_way
            salru_ram #(
                .WIDTH(ENTRY_W),
                .DEPTH(MAX_SETS)
            ) u_ram (
                .i_clk  (i_clk),
                .i_we   (w_we[g]),
                .i_waddr(w_waddr),
                .i_wdata(w_wentry),
                .i_re   (o_job_pop),
                .i_raddr(i_job.set[SW-1:0]),
                .o_rdata(w_rdata[g])
            );
        end
    endgenerate

    always_comb begin
        n_hits   = r_hits;
        n_misses = r_misses;
        if (r_hit) begin
            if (!(&r_hits)) begin
                n_hits = r_hits + TOTAL_W'(1);
            end
        end else begin
            if (!(&r_misses)) begin
                n_misses = r_misses + TOTAL_W'(1);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_line       = r_line;
        n_set        = r_set;
        n_way        = r_way;
        n_hit        = r_hit;
        n_have_empty = r_have_empty;
        n_empty_way  = r_empty_way;
        n_have_lru   = r_have_lru;
        n_lru_way    = r_lru_way;
        n_lru_stamp  = r_lru_stamp;
        case (r_state)
            B_CLEAR: begin
                if (r_clr_addr == SW'(MAX_SETS - 1)) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_job_empty) begin
                    n_line       = i_job.line;
                    n_set        = i_job.set[SW-1:0];
                    n_way        = '0;
                    n_hit        = 1'b0;
                    n_have_empty = 1'b0;
                    n_have_lru   = 1'b0;
                    n_state      = B_SCAN;
                end
            end
            B_SCAN: begin
                if (w_entry.valid && (w_entry.tag == r_line)) begin
                    // lowest matching way wins; stop here
                    n_hit   = 1'b1;
                    n_state = B_COMMIT;
                end else begin
                    if (w_entry.valid) begin
                        if (!r_have_lru || (w_entry.stamp < r_lru_stamp)) begin
                            n_have_lru  = 1'b1;
                            n_lru_way   = r_way[WW-1:0];
                            n_lru_stamp = w_entry.stamp;
                        end
                    end else begin
                        n_have_empty = 1'b1;
                        n_empty_way  = r_way[WW-1:0];
                    end
                    n_way = w_way_inc;
                    if (w_way_inc == i_way_count) begin
                        n_state = B_COMMIT;
                    end
                end
            end
            B_COMMIT: begin
                if (w_commit) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLEAR;
            r_clr_addr  <= '0;
            r_acc       <= '0;
            r_hits      <= '0;
            r_misses    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_clr_addr <= r_clr_addr + SW'(1);
            end
            if (o_job_pop) begin
                r_acc <= r_acc + STAMP_W'(1);
            end
            if (w_commit) begin
                r_hits      <= n_hits;
                r_misses    <= n_misses;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_line       <= n_line;
        r_set        <= n_set;
        r_way        <= n_way;
        r_hit        <= n_hit;
        r_have_empty <= n_have_empty;
        r_empty_way  <= n_empty_way;
        r_have_lru   <= n_have_lru;
        r_lru_way    <= n_lru_way;
        r_lru_stamp  <= n_lru_stamp;
        if (w_commit) begin
            r_out.hit          <= r_hit;
            r_out.way_used     <= w_chosen32[2:0];
            r_out.total_hits   <= n_hits;
            r_out.total_misses <= n_misses;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule
